>>> src/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg: shared types and constants of the voxel ray traversal unit
// Holds the controller state enum, command and status structs and constants.
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int unsigned T_W = 26;
    localparam logic [T_W-1:0] TMAX = {T_W{1'b1}};

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam logic [1:0] REG_LIMIT  = 2'd3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_PICK,
        ST_INDEX,
        ST_READ,
        ST_TEST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;      // capture a cast beat
        logic div_start; // start the per-axis divisions
        logic check;     // start-cell inside test
        logic pick;      // choose axis and step
        logic index;     // form the linear index
        logic read;      // issue map read
        logic hit;       // latch a hit result
        logic miss;      // latch a miss result
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic start_in;
        logic walk_end;  // limit, budget, zero axis or left the map
        logic occupied;
    } t_status;

endpackage

>>> src/vrt_if.sv
// ----------------------------------------------------------------------------
// vrt_if: valid/ready channel interfaces
// Item, result and configuration channels.
// ----------------------------------------------------------------------------
interface vrt_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [11:0] tile_addr;
    logic [2:0]  tile_code;
    logic signed [17:0] origin_x;
    logic signed [17:0] origin_y;
    logic signed [17:0] origin_z;
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_y;
    logic signed [15:0] heading_z;
    modport source (output valid, opcode, tile_addr, tile_code, origin_x, origin_y,
                    origin_z, heading_x, heading_y, heading_z, input ready);
    modport sink (input valid, opcode, tile_addr, tile_code, origin_x, origin_y,
                  origin_z, heading_x, heading_y, heading_z, output ready);
endinterface

interface vrt_out_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [7:0] hit_x;
    logic [7:0] hit_y;
    logic [7:0] hit_z;
    logic [7:0] before_x;
    logic [7:0] before_y;
    logic [7:0] before_z;
    modport source (output valid, hit, hit_x, hit_y, hit_z, before_x, before_y,
                    before_z, input ready);
    modport sink (input valid, hit, hit_x, hit_y, hit_z, before_x, before_y,
                  before_z, output ready);
endinterface

interface vrt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> src/voxel_ray_traversal_unit.sv
// ----------------------------------------------------------------------------
// voxel_ray_traversal_unit: 3D DDA voxel ray caster
// Tile map store plus an Amanatides-Woo walk over it, fixed point.
// ----------------------------------------------------------------------------
// channel   | dir | beat content
// in_ch     | in  | opcode, tile write index/code, ray origin and heading
// out_ch    | out | hit flag, hit cell, previous cell (one beat per cast)
// cfg_ch    | in  | register index and data: size x/y/z, seek limit
//
// tile write: taken only while idle, no result beat
// cast: division of the 3 axes in turn (both quotients of an axis at once),
//   then the start test once it is seen to finish, then for each cell walked
//   the steps pick, index, read and test, and last the done state
// reset clears control state and loads default sizes and limit; map contents are undefined until written
// a waiting result holds in the output register until out_ch takes it
module voxel_ray_traversal_unit
    import vrt_pkg::*;
#(
    parameter int unsigned MAP_WORDS  = 4096,
    parameter int unsigned STEP_LIMIT = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    vrt_in_if.sink    in_ch,
    vrt_out_if.source out_ch,
    vrt_cfg_if.sink   cfg_ch
);
    // configuration registers
    logic [7:0]  r_size [3];
    logic [15:0] r_limit;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_idle, w_result;
    logic    r_out_v;

    logic w_in_take;
    assign in_ch.ready = w_idle;
    assign w_in_take   = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size[0] <= 8'd16;
            r_size[1] <= 8'd16;
            r_size[2] <= 8'd16;
            r_limit   <= 16'd5120;
        end else if (cfg_ch.valid) begin
            case (cfg_ch.index)
                REG_SIZE_X: r_size[0] <= cfg_ch.data[7:0];
                REG_SIZE_Y: r_size[1] <= cfg_ch.data[7:0];
                REG_SIZE_Z: r_size[2] <= cfg_ch.data[7:0];
                REG_LIMIT:  r_limit   <= cfg_ch.data;
                default:    r_limit   <= r_limit;
            endcase
        end
    end

    logic [17:0] w_org [3];
    logic [15:0] w_head [3];
    assign w_org[0] = in_ch.origin_x;
    assign w_org[1] = in_ch.origin_y;
    assign w_org[2] = in_ch.origin_z;
    assign w_head[0] = in_ch.heading_x;
    assign w_head[1] = in_ch.heading_y;
    assign w_head[2] = in_ch.heading_z;

    logic w_hit;
    logic [7:0] w_hc [3];
    logic [7:0] w_pc [3];

    vrt_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cast(w_in_take && in_ch.opcode == OP_CAST),
        .i_out_free(!r_out_v || out_ch.ready),
        .i_status(w_status), .o_cmd(w_cmd), .o_idle(w_idle), .o_result(w_result)
    );

    vrt_datapath #(.MAP_WORDS(MAP_WORDS), .STEP_LIMIT(STEP_LIMIT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .i_wr_en(w_in_take && in_ch.opcode == OP_WRITE),
        .i_wr_index(in_ch.tile_addr), .i_wr_code(in_ch.tile_code),
        .i_org(w_org), .i_head(w_head), .i_size(r_size), .i_limit(r_limit),
        .o_hit(w_hit), .o_hit_c(w_hc), .o_prev_c(w_pc)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_result) begin
            r_out_v <= 1'b1;
        end else if (out_ch.ready) begin
            r_out_v <= 1'b0;
        end
        if (w_result) begin
            out_ch.hit      <= w_hit;
            out_ch.hit_x    <= w_hc[0];
            out_ch.hit_y    <= w_hc[1];
            out_ch.hit_z    <= w_hc[2];
            out_ch.before_x <= w_pc[0];
            out_ch.before_y <= w_pc[1];
            out_ch.before_z <= w_pc[2];
        end
    end
    assign out_ch.valid = r_out_v;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result |-> !r_out_v || out_ch.ready) else $error("result overrun");
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_idle |-> !in_ch.ready) else $error("input taken while busy");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.hit |-> out_ch.hit_x == '0 && out_ch.before_x == '0)
        else $error("miss with nonzero cell");
endmodule

>>> src/vrt_divider.sv
// ----------------------------------------------------------------------------
// vrt_divider: radix-2 restoring divider
// Computes (num << 22) / den one quotient bit a cycle, saturated to TMAX.
// ----------------------------------------------------------------------------
module vrt_divider
    import vrt_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [8:0]     i_num,
    input  logic [14:0]    i_den,
    output logic           o_done,
    output logic [T_W-1:0] o_quot
);
    localparam int unsigned NB = 31; // 9 + 22 dividend bits

    logic [NB-1:0] r_dvd, n_dvd;
    logic [15:0]   r_rem, n_rem;
    logic [NB-1:0] r_q, n_q;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic [14:0]   r_den;
    logic [15:0]   w_trial;

    assign w_trial = {r_rem[14:0], r_dvd[NB-1]};

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_dvd  = {i_num, 22'd0};
            n_rem  = '0;
            n_q    = '0;
            n_cnt  = 5'(NB - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[NB-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_q   = {r_q[NB-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_q   = {r_q[NB-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
            n_cnt = r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_q   <= n_q;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = !r_busy;
    assign o_quot = (r_den == '0 || r_q[NB-1:T_W] != '0) ? TMAX : r_q[T_W-1:0];
endmodule

>>> src/vrt_datapath.sv
// ----------------------------------------------------------------------------
// vrt_datapath: ray walk datapath
// Cell coordinates, plane distances, tile store and result register.
// ----------------------------------------------------------------------------
module vrt_datapath
    import vrt_pkg::*;
#(
    parameter int unsigned MAP_WORDS  = 4096,
    parameter int unsigned STEP_LIMIT = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cmd           i_cmd,
    output t_status        o_status,
    input  logic           i_wr_en,
    input  logic [11:0]    i_wr_index,
    input  logic [2:0]     i_wr_code,
    input  logic [17:0]    i_org [3],
    input  logic [15:0]    i_head [3],
    input  logic [7:0]     i_size [3],
    input  logic [15:0]    i_limit,
    output logic           o_hit,
    output logic [7:0]     o_hit_c [3],
    output logic [7:0]     o_prev_c [3]
);
    localparam int unsigned AW = $clog2(MAP_WORDS);
    localparam int unsigned SW = $clog2(STEP_LIMIT + 1);

    logic [2:0]  mem [MAP_WORDS];
    logic [2:0]  r_rd;

    logic signed [10:0] r_cur [3];
    logic signed [10:0] r_prev [3];
    logic [1:0]  r_dir [3];      // bit1 negative, bit0 nonzero
    logic [7:0]  r_frac [3];
    logic [14:0] r_ad [3];
    logic [T_W-1:0] r_tm [3];
    logic [T_W-1:0] r_dl [3];
    logic [T_W-1:0] r_t;
    logic [SW-1:0]  r_steps;
    logic        r_div_run;
    logic        r_walk_end;
    logic [23:0] r_idx;
    logic        r_idx_ok;
    logic        r_hit_v;

    logic [8:0]  w_dnum;
    logic [14:0] w_dden;
    logic        w_dstart, w_ddone;
    logic [T_W-1:0] w_dq;

    // linear index pieces, one multiply a stage
    logic [15:0] r_yx;

    function automatic logic inside_map(input logic signed [10:0] c [3],
                                        input logic [7:0] s [3]);
        inside_map = !c[0][10] && !c[1][10] && !c[2][10] &&
                     (c[0] < $signed({3'b0, s[0]})) &&
                     (c[1] < $signed({3'b0, s[1]})) &&
                     (c[2] < $signed({3'b0, s[2]}));
    endfunction

    // divider operand sequencing: tm and dl of one axis at a time, axes 0..2
    logic [1:0] r_dcnt;
    logic       r_dpend;
    always_comb begin
        w_dden = r_ad[r_dcnt];
        w_dnum = r_dir[r_dcnt][1] ? {1'b0, r_frac[r_dcnt]}
                                  : 9'(9'd256 - {1'b0, r_frac[r_dcnt]});
        w_dstart = r_dpend;
    end

    vrt_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quot(w_dq)
    );

    // a second divider for 256/|d| keeps the sequence short
    logic w_d2done;
    logic [T_W-1:0] w_dq2;
    vrt_divider u_div_dl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(9'd256), .i_den(w_dden), .o_done(w_d2done), .o_quot(w_dq2)
    );

    // axis choice
    logic [1:0] w_a;
    always_comb begin
        if (r_tm[0] <= r_tm[1] && r_tm[0] <= r_tm[2]) w_a = 2'd0;
        else if (r_tm[1] <= r_tm[2]) w_a = 2'd1;
        else w_a = 2'd2;
    end

    logic [T_W:0] w_nt;
    assign w_nt = {1'b0, r_tm[w_a]} + {1'b0, r_dl[w_a]};

    logic signed [10:0] w_next [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_next[k] = r_cur[k];
        end
        w_next[w_a] = r_dir[w_a][1] ? r_cur[w_a] - 11'sd1 : r_cur[w_a] + 11'sd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run <= 1'b0;
            r_dpend   <= 1'b0;
            r_dcnt    <= '0;
            r_walk_end <= 1'b0;
            r_hit_v   <= 1'b0;
        end else begin
            r_dpend <= 1'b0;
            if (i_cmd.load) begin
                r_div_run <= 1'b1;
                r_dpend   <= 1'b1;
                r_dcnt    <= '0;
                r_walk_end <= 1'b0;
            end else if (r_div_run && !r_dpend && w_ddone && w_d2done) begin
                if (r_dir[r_dcnt][0]) begin
                    r_tm[r_dcnt] <= w_dq;
                    r_dl[r_dcnt] <= w_dq2;
                end else begin
                    r_tm[r_dcnt] <= TMAX;
                    r_dl[r_dcnt] <= TMAX;
                end
                if (r_dcnt == 2'd2) begin
                    r_div_run <= 1'b0;
                end else begin
                    r_dcnt  <= r_dcnt + 2'd1;
                    r_dpend <= 1'b1;
                end
            end
            if (i_cmd.check) begin
                r_walk_end <= 1'b0;
            end
            if (i_cmd.pick) begin
                if (r_t > {i_limit, 8'd0} || r_steps >= SW'(STEP_LIMIT)
                    || !r_dir[w_a][0]) begin
                    r_walk_end <= 1'b1;
                end else begin
                    r_walk_end <= !inside_map(w_next, i_size);
                end
            end
            if (i_cmd.hit) r_hit_v <= 1'b1;
            if (i_cmd.miss) r_hit_v <= 1'b0;
        end

        if (i_cmd.load) begin
            for (int k = 0; k < 3; k++) begin
                logic [18:0] s;
                s = {i_org[k][17], i_org[k]} + 19'd128;
                r_cur[k]  <= $signed(s[18:8]);
                r_frac[k] <= s[7:0];
                r_dir[k]  <= {i_head[k][15], i_head[k] != '0};
                r_ad[k]   <= i_head[k][15] ? 15'(-i_head[k]) : i_head[k][14:0];
            end
            r_t     <= '0;
            r_steps <= '0;
        end
        if (i_cmd.pick && !(r_t > {i_limit, 8'd0} || r_steps >= SW'(STEP_LIMIT)
                            || !r_dir[w_a][0])) begin
            r_prev <= r_cur;
            r_cur  <= w_next;
            r_t    <= r_tm[w_a];
            r_tm[w_a] <= w_nt[T_W] ? TMAX : w_nt[T_W-1:0];
            r_steps <= r_steps + SW'(1);
        end
        if (i_cmd.index) begin
            r_yx <= 16'(r_cur[1][7:0]) * 16'(i_size[2]) + 16'(r_cur[2][7:0]);
        end
        if (i_cmd.read) begin
            r_idx    <= 24'(r_yx) * 24'(i_size[0]) + 24'(r_cur[0][7:0]);
        end
        r_idx_ok <= r_idx < 24'(MAP_WORDS);
        r_rd <= mem[r_idx[AW-1:0]];
        if (i_wr_en && 24'(i_wr_index) < 24'(MAP_WORDS)) begin
            mem[AW'(i_wr_index)] <= i_wr_code;
        end
        if (i_cmd.hit) begin
            for (int k = 0; k < 3; k++) begin
                o_hit_c[k]  <= r_cur[k][7:0];
                o_prev_c[k] <= r_prev[k][7:0];
            end
        end
        if (i_cmd.miss) begin
            for (int k = 0; k < 3; k++) begin
                o_hit_c[k]  <= '0;
                o_prev_c[k] <= '0;
            end
        end
    end

    assign o_hit = r_hit_v;

    assign o_status.div_done = !r_div_run && !r_dpend;
    assign o_status.start_in = inside_map(r_cur, i_size);
    assign o_status.walk_end = r_walk_end;
    assign o_status.occupied = r_idx_ok && (r_rd != '0);
endmodule

>>> src/vrt_controller.sv
// ----------------------------------------------------------------------------
// vrt_controller: cast sequencer
// Steps through divide, start test and the walk loop, one cell per pass.
// ----------------------------------------------------------------------------
module vrt_controller
    import vrt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cast,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_idle,
    output logic    o_result
);
    t_state r_state, n_state;
    logic [1:0] r_wait, n_wait;

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        case (r_state)
            ST_IDLE:  if (i_cast) n_state = ST_DIV;
            ST_DIV:   if (i_status.div_done) n_state = ST_CHECK;
            ST_CHECK: n_state = i_status.start_in ? ST_PICK : ST_DONE;
            ST_PICK:  n_state = ST_INDEX;
            ST_INDEX: begin
                n_state = i_status.walk_end ? ST_DONE : ST_READ;
                n_wait  = 2'd2;
            end
            ST_READ: begin
                n_wait = r_wait - 2'd1;
                if (r_wait == 2'd0) n_state = ST_TEST;
            end
            ST_TEST:  n_state = i_status.occupied ? ST_DONE : ST_PICK;
            ST_DONE:  if (i_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_idle = 1'b0;
        o_result = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_idle = 1'b1;
                o_cmd.load = i_cast;
                o_cmd.div_start = i_cast;
            end
            ST_CHECK: o_cmd.miss = !i_status.start_in;
            ST_PICK:  o_cmd.pick = 1'b1;
            ST_INDEX: begin
                o_cmd.index = 1'b1;
                o_cmd.miss  = i_status.walk_end;
            end
            ST_READ:  o_cmd.read = (r_wait == 2'd2);
            ST_TEST:  o_cmd.hit = i_status.occupied;
            ST_DONE:  o_result = i_out_free;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    a_done_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE && !i_cast |=> r_state == ST_IDLE)
        else $error("controller left idle without a cast");
    a_hit_miss_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.hit && o_cmd.miss)) else $error("hit and miss together");
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result |=> r_state == ST_IDLE) else $error("result not followed by idle");
endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the voxel ray traversal unit
// Clears the low part of the tile map, then sends tile writes and ray casts
// across several map sizes and seek limits. A built-in DDA predictor gives the
// expected result of every accepted cast, checked in order at each result beat.
// ----------------------------------------------------------------------------
module tb;
    import vrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAP_DEPTH   = 4096;
    localparam int unsigned WALK_STEPS  = 1024;
    localparam int unsigned CLEAR_WORDS = 256;     // every random map fits in these
    localparam int unsigned T_SAT       = TMAX;
    localparam int          DRAIN_CYC   = 300;     // idle wait before a register write
    localparam int          STALL_MAX   = 50000;   // watchdog: cycles with no beat
    localparam int          HOLD_CYC    = 600;     // long receiver hold-off

    // one input beat
    typedef struct {
        bit                op;
        bit [11:0]         tidx;
        bit [2:0]          tcode;
        bit signed [17:0]  org [3];
        bit signed [15:0]  hdg [3];
    } t_ray_beat;

    // one result beat
    typedef struct packed {
        bit       hit;
        bit [7:0] hx, hy, hz;
        bit [7:0] bx, by, bz;
    } t_trace_result;

    logic i_clk;
    logic i_rst_n;

    vrt_in_if  in_ch ();
    vrt_out_if out_ch ();
    vrt_cfg_if cfg_ch ();

    voxel_ray_traversal_unit #(
        .MAP_WORDS  (MAP_DEPTH),
        .STEP_LIMIT (WALK_STEPS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg_ch  (cfg_ch)
    );

    // predictor copy of the block state
    bit [2:0]    tile_mirror [MAP_DEPTH];
    int unsigned map_x, map_y, map_z, range_lim;

    t_ray_beat     pending_q [$];
    t_trace_result hit_expect_q [$];

    int  mismatches;
    int  casts_checked;
    bit  quiet;          // no random idle gaps in the last part of the run

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // saturated fixed-point division, quotient in Q.16 distance units
    function automatic int unsigned dist_div(int unsigned num, int unsigned den);
        longint unsigned q;
        if (den == 0) return T_SAT;
        q = (longint'(num) << 22) / den;
        return (q > T_SAT) ? T_SAT : 32'(q);
    endfunction

    function automatic bit cell_in_map(int c [3]);
        return c[0] >= 0 && c[1] >= 0 && c[2] >= 0 &&
               c[0] < int'(map_x) && c[1] < int'(map_y) && c[2] < int'(map_z);
    endfunction

    // amanatides-woo walk over the mirrored map
    function automatic t_trace_result trace_ray(t_ray_beat b);
        t_trace_result r;
        int            cur [3], prv [3], stp [3];
        int unsigned   tnext [3], tcell [3];
        int unsigned   t, lim, steps, idx, nt, ad;
        int            s, d, frac, a;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            s = int'(b.org[k]) + 128;
            d = int'(b.hdg[k]);
            cur[k] = s >>> 8;                  // floor
            frac = s - cur[k] * 256;
            ad = (d < 0) ? -d : d;
            if (d > 0) begin
                stp[k] = 1;
                tnext[k] = dist_div(256 - frac, ad);
                tcell[k] = dist_div(256, ad);
            end else if (d < 0) begin
                stp[k] = -1;
                tnext[k] = dist_div(frac, ad);
                tcell[k] = dist_div(256, ad);
            end else begin
                stp[k] = 0;
                tnext[k] = T_SAT;
                tcell[k] = T_SAT;
            end
        end
        // start cell outside the map: plain miss
        if (!cell_in_map(cur)) return r;
        prv = cur;
        t = 0;
        lim = range_lim << 8;
        steps = 0;
        while (t <= lim) begin
            if (steps >= WALK_STEPS) break;
            steps++;
            if (tnext[0] <= tnext[1] && tnext[0] <= tnext[2]) a = 0;
            else if (tnext[1] <= tnext[2]) a = 1;
            else a = 2;
            if (stp[a] == 0) break;            // only saturated distances left
            prv = cur;
            cur[a] += stp[a];
            t = tnext[a];
            nt = tnext[a] + tcell[a];
            tnext[a] = (nt > T_SAT) ? T_SAT : nt;
            if (!cell_in_map(cur)) break;
            idx = cur[1] * map_x * map_z + cur[2] * map_x + cur[0];
            if (idx < MAP_DEPTH && tile_mirror[idx] != 0) begin
                r.hit = 1'b1;
                r.hx = cur[0][7:0]; r.hy = cur[1][7:0]; r.hz = cur[2][7:0];
                r.bx = prv[0][7:0]; r.by = prv[1][7:0]; r.bz = prv[2][7:0];
                return r;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: feeds in_ch from pending_q, mirrors or predicts at each accepted beat
    // ------------------------------------------------------------------
    t_ray_beat held;
    int        in_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                if (held.op == OP_WRITE) tile_mirror[held.tidx] = held.tcode;
                else hit_expect_q.push_back(trace_ray(held));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    held = pending_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.opcode     <= held.op;
                    in_ch.tile_addr  <= held.tidx;
                    in_ch.tile_code  <= held.tcode;
                    in_ch.origin_x   <= held.org[0];
                    in_ch.origin_y   <= held.org[1];
                    in_ch.origin_z   <= held.org[2];
                    in_ch.heading_x  <= held.hdg[0];
                    in_ch.heading_y  <= held.hdg[1];
                    in_ch.heading_z  <= held.hdg[2];
                    // idle burst after this beat
                    if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 4);
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: result checking plus receiver stalls
    // ------------------------------------------------------------------
    int out_gap;
    int hold_left;
    bit hold_done;

    always @(posedge i_clk) begin
        t_trace_result got, want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.hit, out_ch.hit_x, out_ch.hit_y, out_ch.hit_z,
                        out_ch.before_x, out_ch.before_y, out_ch.before_z};
                if (hit_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat with nothing expected: %p", got);
                end else begin
                    want = hit_expect_q.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("cast %0d: expected %p, got %p",
                                     casts_checked, want, got);
                    end
                end
                casts_checked++;
            end
            // one long hold-off so the block backs up into in_ch
            if (!hold_done && casts_checked == 40) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 4);
            end
        end
    end

    // watchdog on cycles without any beat
    int idle_cycles;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_MAX) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_write(int unsigned idx, int unsigned code);
        t_ray_beat b;
        b.op = OP_WRITE;
        b.tidx = idx[11:0];
        b.tcode = code[2:0];
        for (int k = 0; k < 3; k++) begin
            b.org[k] = 18'($urandom);
            b.hdg[k] = 16'($urandom);
        end
        pending_q.push_back(b);
    endtask

    task automatic push_cast(int ox, int oy, int oz, int hx, int hy, int hz);
        t_ray_beat b;
        b.op = OP_CAST;
        b.tidx = 12'($urandom);
        b.tcode = 3'($urandom);
        b.org[0] = 18'(ox); b.org[1] = 18'(oy); b.org[2] = 18'(oz);
        b.hdg[0] = 16'(hx); b.hdg[1] = 16'(hy); b.hdg[2] = 16'(hz);
        pending_q.push_back(b);
    endtask

    function automatic int unsigned cell_index(int x, int y, int z);
        return y * map_x * map_z + z * map_x + x;
    endfunction

    function automatic int rand_heading();
        if ($urandom_range(0, 7) == 0) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 16384 : -16384;
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    // origin inside the map with a random fraction, cell = floor(o + 0.5)
    function automatic int rand_origin(int unsigned extent);
        return int'($urandom_range(0, extent - 1)) * 256 +
               int'($urandom_range(0, 255)) - 128;
    endfunction

    // random phase: mostly in-map casts with random walls, some noise
    task automatic push_random(int count);
        int unsigned idx;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    idx = cell_index($urandom_range(0, map_x - 1), $urandom_range(0, map_y - 1),
                                     $urandom_range(0, map_z - 1));
                    if (idx >= MAP_DEPTH) idx = $urandom_range(0, MAP_DEPTH - 1);
                    push_write(idx, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7));
                end
                3: push_write($urandom_range(0, MAP_DEPTH - 1), $urandom_range(0, 7));
                4: push_cast(int'($urandom_range(0, 262143)) - 131072,
                             int'($urandom_range(0, 262143)) - 131072,
                             int'($urandom_range(0, 262143)) - 131072,
                             rand_heading(), rand_heading(), rand_heading());
                default: push_cast(rand_origin(map_x), rand_origin(map_y), rand_origin(map_z),
                                   rand_heading(), rand_heading(), rand_heading());
            endcase
        end
    endtask

    // wait until every beat is sent and every result is back, then settle
    task automatic drain();
        while (pending_q.size() > 0 || in_ch.valid || hit_expect_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, int unsigned value);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value[15:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            REG_SIZE_X: map_x = value & 8'hFF;
            REG_SIZE_Y: map_y = value & 8'hFF;
            REG_SIZE_Z: map_z = value & 8'hFF;
            REG_LIMIT:  range_lim = value & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_map(int unsigned sx, int unsigned sy, int unsigned sz, int unsigned lim);
        drain();
        reg_write(REG_SIZE_X, sx);
        reg_write(REG_SIZE_Y, sy);
        reg_write(REG_SIZE_Z, sz);
        reg_write(REG_LIMIT, lim);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        quiet = 1'b0;
        mismatches = 0;
        casts_checked = 0;
        idle_cycles = 0;
        map_x = 16; map_y = 16; map_z = 16;
        range_lim = 5120;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_WRITE;
        in_ch.tile_addr = '0;
        in_ch.tile_code = '0;
        in_ch.origin_x = '0; in_ch.origin_y = '0; in_ch.origin_z = '0;
        in_ch.heading_x = '0; in_ch.heading_y = '0; in_ch.heading_z = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SIZE_X;
        cfg_ch.data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // clear the low store entries; no cast below reads past them
        for (int i = 0; i < CLEAR_WORDS; i++) push_write(i, 0);
        drain();

        // directed part on the reset map (16x16x16), kept in the y = 0 plane
        push_write(cell_index(10, 0, 8), 7);                 // code 7 counts as a wall
        push_write(cell_index(5, 0, 8), 6);
        push_write(cell_index(8, 0, 3), 1);
        push_write(cell_index(8, 0, 8), 2);                  // start cell is never tested
        push_write(MAP_DEPTH - 1, 0);
        push_write(0, 0);
        push_cast(2048, 0, 2048, 16384, 0, 0);               // +x hit
        push_cast(2048, 0, 2048, -16384, 0, 0);              // -x hit
        push_cast(2048, 0, 2048, 0, 0, -16384);              // -z hit
        push_cast(2048, 0, 2048, 0, 0, 16384);               // leaves the map
        push_cast(2048, 0, 2048, 0, -16384, 0);              // leaves below y = 0
        push_cast(2048, 0, 2048, 0, 0, 0);                   // zero heading
        push_cast(-131072, 0, 2048, 16384, 0, 0);            // start outside, low end
        push_cast(131071, 131071, 131071, -16384, -16384, -16384); // outside, high end
        push_cast(2048 + 127, -128, 2048 - 128, 16384, 0, 16384);  // fraction edges
        push_cast(2048, 0, 2048, 1, 0, 0);                   // tiny heading, out of range
        push_cast(-128, -128, -128, 16384, 0, 16384);        // corner cell
        push_cast(3967, 0, 3967, -9000, 0, -16384);          // far corner inward
        push_cast(2048, 0, 2048, 12000, 0, 3000);
        push_cast(2048, 0, 2048, -16384, -1, 1);
        drain();

        // random phases across map sizes and seek limits
        set_map(8, 4, 8, 5120);
        push_random(200);
        set_map(6, 4, 10, 65535);
        push_random(150);
        set_map(1, 1, 1, 0);
        push_random(40);
        set_map(255, 1, 1, 2000);
        push_random(40);
        set_map(1, 255, 1, 65535);
        for (int n = 0; n < 8; n++)
            push_cast(rand_origin(1), rand_origin(255), rand_origin(1),
                      rand_heading(), rand_heading(), rand_heading());
        set_map(5, 7, 7, 300);
        push_random(100);
        set_map(8, 4, 8, 5120);
        drain();
        quiet = 1'b1;
        push_random(100);
        drain();

        mismatches += hit_expect_q.size();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
